@@ hw/rtl/tga_pkg.sv @@
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared types and constants for the TGA run-length stream decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

  // Header walk positions: 0..11 type header, 12..17 image spec.
  localparam logic [4:0] POS_TYPE_CODE  = 5'd2;
  localparam logic [4:0] POS_TYPE_LAST  = 5'd11;
  localparam logic [4:0] POS_WIDTH_LO   = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI   = 5'd13;
  localparam logic [4:0] POS_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] POS_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] POS_DEPTH      = 5'd16;
  localparam logic [4:0] POS_DESCRIPTOR = 5'd17;
  localparam logic [4:0] POS_PIXELS     = 5'd18;
  localparam logic [4:0] POS_DONE       = 5'd19;

  localparam logic [7:0] TYPE_RAW  = 8'd2;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;
  localparam logic [7:0] RUN_BIAS  = 8'd127;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PIXEL     = 3'd1,
    KIND_BAD_TYPE  = 3'd2,
    KIND_BAD_SPEC  = 3'd3,
    KIND_TRUNCATED = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        image_end;
  } result_t;

  // Up to two results per input item, first one in first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ hw/rtl/tga_parser.sv @@
// ----------------------------------------------------------------------------
// TGA header and packet parser
// Registers one input byte, walks the file header and the pixel packets,
// and hands zero, one or two results per byte to the result queue.
// ----------------------------------------------------------------------------
module tga_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid_d,
  input  logic [7:0]    in_byte_d,
  input  logic          in_last_d,
  output logic          busy,
  output tga_pkg::push_t push
);
  import tga_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  logic [4:0]  header_position, header_position_next;
  logic [15:0] stored_width, stored_width_next;
  logic [15:0] stored_height, stored_height_next;
  logic        compressed_flag, compressed_flag_next;
  logic        alpha_flag, alpha_flag_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  packet_pixels_left, packet_pixels_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic        failed_flag, failed_flag_next;
  logic [7:0]  pixel_bytes [3];

  logic        pb_we;
  logic [1:0]  last_byte;
  logic [7:0]  run;
  logic [31:0] area;
  result_t     byte_res;
  logic        byte_res_valid;
  result_t     trunc_res;
  logic        trunc_valid;

  assign busy = in_valid;
  assign area = 32'(stored_width) * 32'(stored_height);
  assign last_byte = alpha_flag ? 2'd3 : 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_d;
    end
    in_byte <= in_byte_d;
    in_last <= in_last_d;
  end

  always_comb begin
    header_position_next    = header_position;
    stored_width_next       = stored_width;
    stored_height_next      = stored_height;
    compressed_flag_next    = compressed_flag;
    alpha_flag_next         = alpha_flag;
    pixels_left_next        = pixels_left;
    packet_pixels_left_next = packet_pixels_left;
    packet_is_run_next      = packet_is_run;
    byte_in_pixel_next      = byte_in_pixel;
    failed_flag_next        = failed_flag;
    pb_we                   = 1'b0;
    run                     = 8'd0;
    byte_res                = '0;
    byte_res_valid          = 1'b0;
    trunc_res               = '0;
    trunc_valid             = 1'b0;

    if (in_valid) begin
      if (header_position < POS_WIDTH_LO) begin
        if (header_position == POS_TYPE_CODE) begin
          if (in_byte == TYPE_RLE) begin
            compressed_flag_next = 1'b1;
          end else if (in_byte == TYPE_RAW) begin
            compressed_flag_next = 1'b0;
          end else begin
            failed_flag_next = 1'b1;
          end
        end else if (in_byte != 8'd0) begin
          failed_flag_next = 1'b1;
        end
        if (header_position == POS_TYPE_LAST) begin
          if (failed_flag_next) begin
            byte_res.kind        = KIND_BAD_TYPE;
            byte_res.image_end   = 1'b1;
            byte_res_valid       = 1'b1;
            header_position_next = POS_DONE;
          end else begin
            header_position_next = POS_WIDTH_LO;
          end
        end else begin
          header_position_next = header_position + 5'd1;
        end
      end else if (header_position == POS_WIDTH_LO) begin
        stored_width_next[7:0] = in_byte;
        header_position_next   = POS_WIDTH_HI;
      end else if (header_position == POS_WIDTH_HI) begin
        stored_width_next[15:8] = in_byte;
        header_position_next    = POS_HEIGHT_LO;
      end else if (header_position == POS_HEIGHT_LO) begin
        stored_height_next[7:0] = in_byte;
        header_position_next    = POS_HEIGHT_HI;
      end else if (header_position == POS_HEIGHT_HI) begin
        stored_height_next[15:8] = in_byte;
        header_position_next     = POS_DEPTH;
      end else if (header_position == POS_DEPTH) begin
        alpha_flag_next = (in_byte == DEPTH_32);
        if (in_byte != DEPTH_24 && in_byte != DEPTH_32) begin
          failed_flag_next = 1'b1;
        end
        header_position_next = POS_DESCRIPTOR;
      end else if (header_position == POS_DESCRIPTOR) begin
        byte_res_valid = 1'b1;
        if (failed_flag || stored_width == 16'd0 || stored_height == 16'd0) begin
          byte_res.kind        = KIND_BAD_SPEC;
          byte_res.image_end   = 1'b1;
          header_position_next = POS_DONE;
        end else begin
          byte_res.kind           = KIND_HEADER;
          byte_res.image_width    = stored_width;
          byte_res.image_height   = stored_height;
          byte_res.has_alpha      = alpha_flag;
          pixels_left_next        = area;
          packet_pixels_left_next = 8'd0;
          packet_is_run_next      = 1'b0;
          byte_in_pixel_next      = 2'd0;
          header_position_next    = POS_PIXELS;
        end
      end else if (header_position == POS_PIXELS) begin
        if (compressed_flag && packet_pixels_left == 8'd0) begin
          // Packet header: top bit selects a run packet.
          packet_is_run_next = in_byte[7];
          if (in_byte[7]) begin
            packet_pixels_left_next = in_byte - RUN_BIAS;
          end else begin
            packet_pixels_left_next = in_byte + 8'd1;
          end
          byte_in_pixel_next = 2'd0;
        end else if (byte_in_pixel < last_byte) begin
          pb_we              = 1'b1;
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end else begin
          byte_in_pixel_next = 2'd0;
          if (compressed_flag && packet_is_run) begin
            run                     = packet_pixels_left;
            packet_pixels_left_next = 8'd0;
          end else begin
            run = 8'd1;
            if (compressed_flag && packet_pixels_left != 8'd0) begin
              packet_pixels_left_next = packet_pixels_left - 8'd1;
            end
          end
          if (32'(run) > pixels_left) begin
            run = pixels_left[7:0];
          end
          pixels_left_next     = pixels_left - 32'(run);
          byte_res_valid       = 1'b1;
          byte_res.kind        = KIND_PIXEL;
          // On 24-bit images the last byte is red itself.
          byte_res.red         = alpha_flag ? pixel_bytes[2] : in_byte;
          byte_res.green       = pixel_bytes[1];
          byte_res.blue        = pixel_bytes[0];
          byte_res.alpha       = alpha_flag ? in_byte : 8'd0;
          byte_res.run_length  = run;
          byte_res.has_alpha   = alpha_flag;
          byte_res.image_end   = (pixels_left_next == 32'd0);
          if (pixels_left_next == 32'd0) begin
            header_position_next = POS_DONE;
          end
        end
      end

      if (in_last) begin
        if (header_position_next != POS_DONE) begin
          trunc_valid         = 1'b1;
          trunc_res.kind      = KIND_TRUNCATED;
          trunc_res.image_end = 1'b1;
        end
        header_position_next    = 5'd0;
        stored_width_next       = 16'd0;
        stored_height_next      = 16'd0;
        compressed_flag_next    = 1'b0;
        alpha_flag_next         = 1'b0;
        pixels_left_next        = 32'd0;
        packet_pixels_left_next = 8'd0;
        packet_is_run_next      = 1'b0;
        byte_in_pixel_next      = 2'd0;
        failed_flag_next        = 1'b0;
      end
    end

    push.count  = 2'(byte_res_valid) + 2'(trunc_valid);
    push.first  = byte_res_valid ? byte_res : trunc_res;
    push.second = trunc_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position    <= 5'd0;
      stored_width       <= 16'd0;
      stored_height      <= 16'd0;
      compressed_flag    <= 1'b0;
      alpha_flag         <= 1'b0;
      pixels_left        <= 32'd0;
      packet_pixels_left <= 8'd0;
      packet_is_run      <= 1'b0;
      byte_in_pixel      <= 2'd0;
      failed_flag        <= 1'b0;
    end else begin
      header_position    <= header_position_next;
      stored_width       <= stored_width_next;
      stored_height      <= stored_height_next;
      compressed_flag    <= compressed_flag_next;
      alpha_flag         <= alpha_flag_next;
      pixels_left        <= pixels_left_next;
      packet_pixels_left <= packet_pixels_left_next;
      packet_is_run      <= packet_is_run_next;
      byte_in_pixel      <= byte_in_pixel_next;
      failed_flag        <= failed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pb_we) begin
      pixel_bytes[byte_in_pixel] <= in_byte;
    end
  end

endmodule

@@ hw/rtl/tga_out_fifo.sv @@
// ----------------------------------------------------------------------------
// TGA result queue
// Small register queue that takes up to two results per cycle and delivers
// one result per cycle to the output stream while the sink is ready.
// ----------------------------------------------------------------------------
module tga_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  tga_pkg::push_t              push,
  input  logic                        pop,
  output logic                        valid,
  output tga_pkg::result_t            head,
  output logic [tga_pkg::FIFO_CW-1:0] count
);
  import tga_pkg::*;

  result_t             entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr, wr_ptr_next;
  logic [FIFO_AW-1:0]  rd_ptr, rd_ptr_next;
  logic [FIFO_CW-1:0]  count_next;
  logic [FIFO_AW-1:0]  wr_ptr_plus1;

  assign valid        = (count != '0);
  assign head         = entries[rd_ptr];
  assign wr_ptr_plus1 = wr_ptr + FIFO_AW'(1);

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_AW'(push.count);
    rd_ptr_next = rd_ptr + FIFO_AW'(pop);
    count_next  = count + FIFO_CW'(push.count) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

endmodule

@@ hw/rtl/tga_rle_stream_decoder.sv @@
// An accepted byte passes the parse register and then the result queue to m_tvalid.
// Throughput: one byte per cycle; the result queue holds eight results and the input
// side stalls once more than four are waiting with a byte still in the parse register.
// Each byte gives at most two results, so a slow sink throttles the input.
// Reset (rst, synchronous) clears the header walk, counters and queue pointers;
// the parser then expects the first byte of a new file.
// ----------------------------------------------------------------------------
// TGA run-length stream decoder
// Parses a TGA file byte stream and emits a header item, RGB(A) pixel runs
// and error items on a streaming output.
// ----------------------------------------------------------------------------
module tga_rle_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // red, green, blue, alpha, run_length, image_width,
                                 // image_height, has_alpha, zero fill
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast    // image_end
);
  import tga_pkg::*;

  push_t              push;
  result_t            head;
  logic               busy;
  logic [FIFO_CW-1:0] count;
  logic               accept;

  // Leave room for two results from the byte in flight and two from the next one.
  assign s_tready = busy ? (count <= FIFO_CW'(FIFO_DEPTH - 4))
                         : (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept   = s_tvalid && s_tready;

  tga_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid_d (accept),
    .in_byte_d  (s_tdata),
    .in_last_d  (s_tlast),
    .busy       (busy),
    .push       (push)
  );

  tga_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (m_tvalid && m_tready),
    .valid (m_tvalid),
    .head  (head),
    .count (count)
  );

  assign m_tdata = {7'd0, head.has_alpha, head.image_height, head.image_width,
                    head.run_length, head.alpha, head.blue, head.green, head.red};
  assign m_tuser = head.kind;
  assign m_tlast = head.image_end;

endmodule

@@ hw/rtl/tga_checker.sv @@
// ----------------------------------------------------------------------------
// TGA decoder port checker
// Watches the top-level ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
module tga_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import tga_pkg::*;

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // Every error ends the image.
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_BAD_TYPE || m_tuser == KIND_BAD_SPEC
      || m_tuser == KIND_TRUNCATED) |-> m_tlast && m_tdata[39:0] == 40'd0)
    else $error("error item without end mark or with pixel data");

  // A pixel run is never empty and never longer than one run packet.
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PIXEL |-> m_tdata[39:32] != 8'd0
      && m_tdata[39:32] <= 8'd128 && m_tdata[71:40] == 32'd0)
    else $error("pixel run length out of range");

  // A header carries a nonzero size and never ends the image.
  a_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_HEADER |-> !m_tlast && m_tdata[55:40] != 16'd0
      && m_tdata[71:56] != 16'd0 && m_tdata[39:0] == 40'd0)
    else $error("malformed header item");

  // Only the five defined kinds appear.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= KIND_TRUNCATED)
    else $error("undefined result kind");

endmodule

bind tga_rle_stream_decoder tga_checker u_tga_checker (.*);
